>>> hw/rtl/bmp565_pkg.sv
// shared types and constants for the bmp pixel stream to rgb565 writer
// no dependencies
package bmp565_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;

  // field widths
  localparam int COORD_W = 12;
  localparam int SCR_W   = COORD_W + 1;
  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_IMAGE_W     = 3'd2,
    REG_IMAGE_H     = 3'd3,
    REG_DEPTH_24    = 3'd4,
    REG_TRANSPARENT = 3'd5,
    REG_MASK_EN     = 3'd6
  } cfg_reg_t;

  // live configuration, with zero width and height read as one
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] eff_width;
    logic [COORD_W-1:0] eff_height;
    logic               depth_is_24;
    logic [COLOR_W-1:0] transparent_color;
    logic               mask_enable;
  } cfg_t;

  // one finished pixel before placement
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_t;

endpackage

>>> hw/rtl/bmp565_cfg_regs.sv
// configuration register file of the bmp pixel stream writer
// depends on bmp565_pkg
module bmp565_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bmp565_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
  output bmp565_pkg::cfg_t              cfg
);
  import bmp565_pkg::*;

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] image_width;
  logic [COORD_W-1:0] image_height;
  logic               depth_is_24;
  logic [COLOR_W-1:0] transparent_color;
  logic               mask_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x          <= '0;
      origin_y          <= '0;
      image_width       <= COORD_W'(1);
      image_height      <= COORD_W'(1);
      depth_is_24       <= 1'b0;
      transparent_color <= '0;
      mask_enable       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    origin_x          <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y          <= cfg_data[COORD_W-1:0];
        REG_IMAGE_W:     image_width       <= cfg_data[COORD_W-1:0];
        REG_IMAGE_H:     image_height      <= cfg_data[COORD_W-1:0];
        REG_DEPTH_24:    depth_is_24       <= cfg_data[0];
        REG_TRANSPARENT: transparent_color <= cfg_data[COLOR_W-1:0];
        REG_MASK_EN:     mask_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.origin_x          = origin_x;
    cfg.origin_y          = origin_y;
    cfg.eff_width         = (image_width == '0) ? COORD_W'(1) : image_width;
    cfg.eff_height        = (image_height == '0) ? COORD_W'(1) : image_height;
    cfg.depth_is_24       = depth_is_24;
    cfg.transparent_color = transparent_color;
    cfg.mask_enable       = mask_enable;
  end

endmodule

>>> hw/rtl/bmp565_unpack.sv
// byte assembly, row/column/padding counters and the pixel register
// depends on bmp565_pkg
module bmp565_unpack (
  input  logic                         clk,
  input  logic                         rst,
  input  bmp565_pkg::cfg_t             cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bmp565_pkg::BYTE_W-1:0] pixel_byte,
  input  logic                         place_ready,
  output logic                         pix_valid,
  output bmp565_pkg::pixel_t           pix
);
  import bmp565_pkg::*;

  logic [1:0]         byte_phase, byte_phase_next;
  logic [COLOR_W-1:0] held_bytes, held_bytes_next;
  logic [COORD_W-1:0] column_index, column_index_next;
  logic [COORD_W-1:0] rows_remaining, rows_remaining_next;
  logic [1:0]         pad_remaining, pad_remaining_next;

  logic               accept;
  logic               starting;
  logic [COORD_W-1:0] rows_cur, col_cur;
  logic [1:0]         phase_cur, pad_cur;
  logic               done;
  logic [COLOR_W-1:0] color;
  logic [COLOR_W-1:0] word16;
  logic [1:0]         pad24, pad16;
  logic [1:0]         row_bytes_mod4;

  assign in_stall = pix_valid && !place_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // a new image starts when no rows remain
    starting  = (rows_remaining == '0);
    rows_cur  = starting ? cfg.eff_height : rows_remaining;
    col_cur   = starting ? '0 : column_index;
    phase_cur = starting ? 2'd0 : byte_phase;
    pad_cur   = starting ? 2'd0 : pad_remaining;

    row_bytes_mod4 = 2'(cfg.eff_width[1:0] * 2'd3);
    pad24          = 2'd0 - row_bytes_mod4;
    pad16          = {cfg.eff_width[0], 1'b0};
    word16         = {pixel_byte, held_bytes[BYTE_W-1:0]};

    rows_remaining_next = rows_cur;
    column_index_next   = col_cur;
    byte_phase_next     = phase_cur;
    pad_remaining_next  = pad_cur;
    held_bytes_next     = held_bytes;
    done                = 1'b0;
    color               = '0;

    priority if (pad_cur != 2'd0) begin
      pad_remaining_next = pad_cur - 2'd1;
      if (pad_cur == 2'd1) begin
        rows_remaining_next = rows_cur - COORD_W'(1);
      end
    end else if (cfg.depth_is_24) begin
      unique case (phase_cur)
        2'd0: begin
          held_bytes_next = {8'h00, pixel_byte};
          byte_phase_next = 2'd1;
        end
        2'd1: begin
          held_bytes_next = {pixel_byte, held_bytes[BYTE_W-1:0]};
          byte_phase_next = 2'd2;
        end
        default: begin
          done  = 1'b1;
          color = {pixel_byte[7:3], held_bytes[15:10], held_bytes[7:3]};
        end
      endcase
    end else begin
      if (phase_cur == 2'd0) begin
        held_bytes_next = {8'h00, pixel_byte};
        byte_phase_next = 2'd1;
      end else begin
        // 1:5:5:5 to 5:6:5, msb dropped and green gets a zero lsb
        done  = 1'b1;
        color = {word16[14:5], 1'b0, word16[4:0]};
      end
    end

    if (done) begin
      byte_phase_next = 2'd0;
      held_bytes_next = '0;
      if (col_cur >= cfg.eff_width - COORD_W'(1)) begin
        column_index_next  = '0;
        pad_remaining_next = cfg.depth_is_24 ? pad24 : pad16;
        if (pad_remaining_next == 2'd0) begin
          rows_remaining_next = rows_cur - COORD_W'(1);
        end
      end else begin
        column_index_next = col_cur + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= 2'd0;
      held_bytes     <= '0;
      column_index   <= '0;
      rows_remaining <= '0;
      pad_remaining  <= 2'd0;
      pix_valid      <= 1'b0;
    end else begin
      if (accept) begin
        byte_phase     <= byte_phase_next;
        held_bytes     <= held_bytes_next;
        column_index   <= column_index_next;
        rows_remaining <= rows_remaining_next;
        pad_remaining  <= pad_remaining_next;
        pix_valid      <= done;
      end else if (place_ready) begin
        pix_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      pix.color <= color;
      pix.col   <= col_cur;
      pix.row   <= rows_cur - COORD_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_pad_only_between_pixels: assert property (@(posedge clk) disable iff (rst)
    pad_remaining != 2'd0 |-> byte_phase == 2'd0)
    else $error("padding pending in the middle of a pixel");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    rows_remaining == '0 |-> (column_index == '0 && pad_remaining == 2'd0))
    else $error("counters not clear between images");

  a_pixel_held_while_blocked: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !place_ready) |=> (pix_valid && $stable(pix)))
    else $error("pending pixel lost while placement blocked");
`endif

endmodule

>>> hw/rtl/bmp565_place.sv
// screen placement, clipping, transparency and the output register
// depends on bmp565_pkg
module bmp565_place (
  input  logic                           clk,
  input  logic                           rst,
  input  bmp565_pkg::cfg_t               cfg,
  input  logic                           pix_valid,
  input  bmp565_pkg::pixel_t             pix,
  output logic                           place_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bmp565_pkg::ADDR_W-1:0]  write_address,
  output logic [bmp565_pkg::COLOR_W-1:0] write_color
);
  import bmp565_pkg::*;

  localparam logic [SCR_W-1:0] SCR_W_C = SCR_W'(SCREEN_WIDTH);
  localparam logic [SCR_W-1:0] SCR_H_C = SCR_W'(SCREEN_HEIGHT);

  logic [SCR_W-1:0]   sx, sy;
  logic [2*SCR_W-1:0] row_base;
  logic [2*SCR_W-1:0] addr_full;
  logic               visible, hidden, keep;

  always_comb begin
    sx        = SCR_W'(cfg.origin_x) + SCR_W'(pix.col);
    sy        = SCR_W'(cfg.origin_y) + SCR_W'(pix.row);
    visible   = (sx < SCR_W_C) && (sy < SCR_H_C);
    hidden    = cfg.mask_enable && (pix.color == cfg.transparent_color);
    keep      = pix_valid && visible && !hidden;
    row_base  = sy * SCR_W_C;
    addr_full = row_base + (2*SCR_W)'(sx);
  end

  assign place_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (place_ready) begin
      out_valid <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (place_ready && keep) begin
      write_address <= addr_full[ADDR_W-1:0];
      write_color   <= pix.color;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_transparent_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(cfg.mask_enable && write_color == cfg.transparent_color))
    else $error("transparent pixel written");

  a_dropped_pixel_gives_nothing: assert property (@(posedge clk) disable iff (rst)
    (place_ready && pix_valid && !visible) |=> !out_valid)
    else $error("clipped pixel reached the output");
`endif

endmodule

>>> hw/rtl/bmp_pixel_stream_to_rgb565_top.sv
// top level of the bmp pixel stream to rgb565 framebuffer writer
// depends on bmp565_pkg, bmp565_cfg_regs, bmp565_unpack, bmp565_place
//
// usage:
//   input channel: one raw byte of the bmp pixel array per transfer
//   (pixel_byte), row padding included, rows bottom-up as stored in the file
//   output channel: one framebuffer write per visible, non-transparent
//   pixel (write_address = row * screen width + column, write_color rgb565)
//   config port: cfg_write/cfg_index/cfg_data, written while the block is idle
// path: the byte that completes a pixel lands in the pixel register at its
//   own transfer edge and then passes to the output register, from which its
//   write transfers; a stall can hold it in either register
// throughput: one byte per cycle while in_stall is low; the counters update
//   in the transfer cycle and the row-base multiply sits in the placement stage
// reset: counters, phase and valids clear, registers return to width and
//   height one, 16-bit mode, no masking, origin zero; the next byte starts
//   a new image
// stall: a stalled result holds in the output register while the pixel
//   register still takes one more pixel; in_stall rises only when both are full
module bmp_pixel_stream_to_rgb565_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [bmp565_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte stream in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bmp565_pkg::BYTE_W-1:0]     pixel_byte,
  // framebuffer writes out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmp565_pkg::ADDR_W-1:0]     write_address,
  output logic [bmp565_pkg::COLOR_W-1:0]    write_color
);
  import bmp565_pkg::*;

  cfg_t   cfg;
  pixel_t pix;
  logic   pix_valid;
  logic   place_ready;

  // live configuration registers
  bmp565_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte assembly and image walk; holds one finished pixel
  bmp565_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_byte  (pixel_byte),
    .place_ready (place_ready),
    .pix_valid   (pix_valid),
    .pix         (pix)
  );

  // address, clip and mask, then the output register
  bmp565_place u_place (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .place_ready   (place_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_address (write_address),
    .write_color   (write_color)
  );

endmodule
